FILE: rtl/color_contrast_ratio_check_core_defines.svh
// Assertion macros shared by the checker of the contrast-ratio core.
// Depends on nothing; every macro expects clk and rst_n in scope.
`ifndef COLOR_CONTRAST_RATIO_CHECK_CORE_DEFINES_SVH
`define COLOR_CONTRAST_RATIO_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("contrast core check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("contrast core check failed");

`endif

FILE: rtl/ccrc_pkg.sv
// Shared constants and elaboration-time table functions of the contrast-ratio core.
// Depends on nothing; imported by every module of the core.
package ccrc_pkg;

    localparam int CH_NUM = 3;       // red, green, blue
    localparam int COLOR_NUM = 2;    // foreground, background
    localparam int TH_W = 8;         // Q4.4 threshold
    localparam int CFG_IDX_W = 2;
    localparam int WEIGHT_BITS = 14; // 10000 < 2^14

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_TH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_TH  = 2'd1;

    localparam logic [TH_W-1:0] NORMAL_TH_RESET = 8'd72;
    localparam logic [TH_W-1:0] LARGE_TH_RESET  = 8'd48;

    // Luminance weights scaled by 10000, in channel order red, green, blue.
    localparam logic [WEIGHT_BITS-1:0] LUMA_WEIGHT [CH_NUM] = '{14'd2126, 14'd7152, 14'd722};
    localparam int OFFSET_SCALE = 500; // 0.05 scaled by 10000

    // Chained fifth power in Q0.31.
    function automatic logic [63:0] fifth_power_q31(input logic [63:0] r);
        logic [63:0] p;
        p = (r * r) >> 31;
        p = (p * r) >> 31;
        p = (p * r) >> 31;
        p = (p * r) >> 31;
        return p;
    endfunction

    // sRGB transfer curve for one 8-bit code, f fraction bits. Evaluated at
    // elaboration only, to fill the constant lookup table.
    function automatic logic [63:0] lin_entry(input logic [63:0] c, input logic [63:0] f);
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] y;
        if (c <= 64'd10) begin
            return (((c * 64'd5) << f) + 64'd8236) / 64'd16473;
        end
        x = (((64'd1000 * c + 64'd14025) << 31) + 64'd134512) / 64'd269025;
        s = (x * x) >> 31;
        lo = 64'd0;
        hi = 64'd1 << 31;
        // Largest root whose fifth power stays at or below s.
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (fifth_power_q31(mid) <= s) begin
                lo = mid;
            end
            else begin
                hi = mid - 64'd1;
            end
        end
        y = (s * lo) >> 31;
        return (y + (64'd1 << (64'd30 - f))) >> (64'd31 - f);
    endfunction

endpackage

FILE: rtl/ccrc_lin.sv
// Input register and sRGB linearization stage of the contrast-ratio core.
// Depends on ccrc_pkg for the table function and channel counts.
module ccrc_lin
    import ccrc_pkg::*;
#(
    parameter int F = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               color [COLOR_NUM],
    input  logic [TH_W-1:0]           th,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [F:0]                lin [COLOR_NUM][CH_NUM],
    output logic [TH_W-1:0]           out_th
);

    logic [F:0]      lin_rom [256];
    logic [7:0]      code_reg [COLOR_NUM][CH_NUM];
    logic [TH_W-1:0] th_a_reg;
    logic            va_reg;
    logic [F:0]      lin_reg [COLOR_NUM][CH_NUM];
    logic [TH_W-1:0] th_b_reg;
    logic            vb_reg;
    logic            rdy_b;

    // Constant table: one entry per 8-bit code, worked out at elaboration.
    for (genvar g = 0; g < 256; g++) begin : g_rom
        assign lin_rom[g] = (F+1)'(lin_entry(64'(g), 64'(F)));
    end

    assign rdy_b    = !vb_reg || out_ready;
    assign in_ready = !va_reg || rdy_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                va_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int k = 0; k < COLOR_NUM; k++)
            begin
                code_reg[k][0] <= color[k][31:24];
                code_reg[k][1] <= color[k][23:16];
                code_reg[k][2] <= color[k][15:8];
            end
            th_a_reg <= th;
        end
        if (rdy_b && va_reg)
        begin
            for (int k = 0; k < COLOR_NUM; k++)
            begin
                for (int j = 0; j < CH_NUM; j++)
                begin
                    lin_reg[k][j] <= lin_rom[code_reg[k][j]];
                end
            end
            th_b_reg <= th_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign lin       = lin_reg;
    assign out_th    = th_b_reg;

endmodule

FILE: rtl/ccrc_luma.sv
// Weighted luminance stages: per-channel weight products, then their sum.
// Depends on ccrc_pkg for the weights and counts.
module ccrc_luma
    import ccrc_pkg::*;
#(
    parameter int F = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [F:0]                    lin [COLOR_NUM][CH_NUM],
    input  logic [TH_W-1:0]               th,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [F+WEIGHT_BITS-1:0]      luma [COLOR_NUM],
    output logic [TH_W-1:0]               out_th
);

    localparam int WW = F + WEIGHT_BITS;

    logic [WW-1:0]   prod_reg [COLOR_NUM][CH_NUM];
    logic [TH_W-1:0] th_c_reg;
    logic            vc_reg;
    logic [WW-1:0]   luma_reg [COLOR_NUM];
    logic [TH_W-1:0] th_d_reg;
    logic            vd_reg;
    logic            rdy_d;

    assign rdy_d    = !vd_reg || out_ready;
    assign in_ready = !vc_reg || rdy_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                vc_reg <= in_valid;
            end
            if (rdy_d)
            begin
                vd_reg <= vc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int k = 0; k < COLOR_NUM; k++)
            begin
                for (int j = 0; j < CH_NUM; j++)
                begin
                    prod_reg[k][j] <= WW'(lin[k][j]) * WW'(LUMA_WEIGHT[j]);
                end
            end
            th_c_reg <= th;
        end
        if (rdy_d && vc_reg)
        begin
            for (int k = 0; k < COLOR_NUM; k++)
            begin
                luma_reg[k] <= prod_reg[k][0] + prod_reg[k][1] + prod_reg[k][2];
            end
            th_d_reg <= th_c_reg;
        end
    end

    assign out_valid = vd_reg;
    assign luma      = luma_reg;
    assign out_th    = th_d_reg;

endmodule

FILE: rtl/ccrc_decide.sv
// Ratio decision stages: order and offset, threshold product, final compare.
// Depends on ccrc_pkg for the offset scale and widths.
module ccrc_decide
    import ccrc_pkg::*;
#(
    parameter int F = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [F+WEIGHT_BITS-1:0]      luma [COLOR_NUM],
    input  logic [TH_W-1:0]               th,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          passes
);

    localparam int WW = F + WEIGHT_BITS;
    localparam int PW = WW + TH_W;
    localparam logic [WW-1:0] OFFSET = WW'(OFFSET_SCALE) << F;

    logic [WW-1:0]   hi_reg;
    logic [WW-1:0]   lo_reg;
    logic [TH_W-1:0] th_e_reg;
    logic            ve_reg;
    logic [PW-1:0]   big_reg;
    logic [PW-1:0]   prod_reg;
    logic            vf_reg;
    logic            pass_reg;
    logic            vg_reg;
    logic            rdy_f;
    logic            rdy_g;
    logic            fg_brighter;

    assign fg_brighter = luma[0] > luma[1];

    assign rdy_g    = !vg_reg || out_ready;
    assign rdy_f    = !vf_reg || rdy_g;
    assign in_ready = !ve_reg || rdy_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                ve_reg <= in_valid;
            end
            if (rdy_f)
            begin
                vf_reg <= ve_reg;
            end
            if (rdy_g)
            begin
                vg_reg <= vf_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hi_reg   <= (fg_brighter ? luma[0] : luma[1]) + OFFSET;
            lo_reg   <= (fg_brighter ? luma[1] : luma[0]) + OFFSET;
            th_e_reg <= th;
        end
        if (rdy_f && ve_reg)
        begin
            // The brighter side is scaled by 16 to match the Q4.4 threshold.
            big_reg  <= PW'(hi_reg) << 4;
            prod_reg <= PW'(lo_reg) * PW'(th_e_reg);
        end
        if (rdy_g && vf_reg)
        begin
            pass_reg <= big_reg >= prod_reg;
        end
    end

    assign out_valid = vg_reg;
    assign passes    = pass_reg;

endmodule

FILE: rtl/color_contrast_ratio_check_core.sv
// Contrast-ratio check core: an accepted input word passes through the seven-stage
// pipeline, one register per stage, to its result word. Throughput is one word per
// cycle while the output is not stalled.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// thresholds with 72 (normal text) and 48 (large text).
module color_contrast_ratio_check_core
    import ccrc_pkg::*;
#(
    parameter int LUMA_FRACTION_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // foreground_color[31:0], background_color[63:32]
    input  logic                  s_tuser,   // large_text
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // passes[0], zero fill above
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TH_W-1:0]       cfg_data
);

    localparam int F  = LUMA_FRACTION_BITS;
    localparam int WW = F + WEIGHT_BITS;

    logic [TH_W-1:0] normal_th_reg;
    logic [TH_W-1:0] large_th_reg;
    logic [31:0]     color [COLOR_NUM];
    logic [TH_W-1:0] th_sel;

    logic            lin_valid;
    logic            lin_ready;
    logic [F:0]      lin [COLOR_NUM][CH_NUM];
    logic [TH_W-1:0] lin_th;

    logic            luma_valid;
    logic            luma_ready;
    logic [WW-1:0]   luma [COLOR_NUM];
    logic [TH_W-1:0] luma_th;

    logic            passes;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_th_reg <= NORMAL_TH_RESET;
            large_th_reg  <= LARGE_TH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NORMAL_TH: normal_th_reg <= cfg_data;
                REG_LARGE_TH:  large_th_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign color[0] = s_tdata[31:0];
    assign color[1] = s_tdata[63:32];
    assign th_sel   = s_tuser ? large_th_reg : normal_th_reg;

    ccrc_lin #(.F(F)) u_lin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .color     (color),
        .th        (th_sel),
        .out_valid (lin_valid),
        .out_ready (lin_ready),
        .lin       (lin),
        .out_th    (lin_th)
    );

    ccrc_luma #(.F(F)) u_luma (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lin_valid),
        .in_ready  (lin_ready),
        .lin       (lin),
        .th        (lin_th),
        .out_valid (luma_valid),
        .out_ready (luma_ready),
        .luma      (luma),
        .out_th    (luma_th)
    );

    ccrc_decide #(.F(F)) u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (luma_valid),
        .in_ready  (luma_ready),
        .luma      (luma),
        .th        (luma_th),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .passes    (passes)
    );

    assign m_tdata = {7'b0, passes};

endmodule

FILE: rtl/ccrc_checker.sv
// Port-level checker of the contrast-ratio core, bound to the top level.
// Depends on the assertion macros in the defines header.
`include "color_contrast_ratio_check_core_defines.svh"

module ccrc_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata
);

    // A stalled result word holds its value.
    `CCRC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Only the pass bit of the result word may be set.
    `CCRC_ASSERT_IMP(a_out_pad, m_tvalid, m_tdata[7:1] == 7'd0)

    // With the output side taking words, no stage can hold up the input.
    `CCRC_ASSERT_IMP(a_no_backpressure, m_tready, s_tready)

    // An accepted word comes out as a result word when the output side keeps taking words.
    `CCRC_ASSERT_NXT(a_latency, s_tvalid && s_tready && m_tready ##1 m_tready [*6], m_tvalid)

endmodule

bind color_contrast_ratio_check_core ccrc_checker u_ccrc_checker (.*);
